// ----- hw/rtl/srfr_pkg.sv -----
`timescale 1ns / 1ps

package srfr_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_START   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 3'd4;

    localparam logic [7:0]  START_RESET   = 8'h7E;
    localparam logic [7:0]  VERSION_RESET = 8'hFF;
    localparam logic [7:0]  LENGTH_RESET  = 8'h06;
    localparam logic [7:0]  END_RESET     = 8'hEF;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_TICK = 2'd1,
        CMD_ARM  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_VERSION  = 3'd1,
        ST_LENGTH   = 3'd2,
        ST_CHECKSUM = 3'd3,
        ST_END      = 3'd4,
        ST_TIMEOUT  = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        PH_START     = 4'd0,
        PH_VERSION   = 4'd1,
        PH_LENGTH    = 4'd2,
        PH_COMMAND   = 4'd3,
        PH_FEEDBACK  = 4'd4,
        PH_PARAM_HI  = 4'd5,
        PH_PARAM_LO  = 4'd6,
        PH_CHECK_HI  = 4'd7,
        PH_CHECK_LO  = 4'd8,
        PH_END       = 4'd9
    } phase_t;

    typedef struct packed {
        logic [7:0]  start_code;
        logic [7:0]  version_code;
        logic [7:0]  length_code;
        logic [7:0]  end_code;
        logic [15:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        phase_t      phase;
        logic        armed;
        logic [15:0] elapsed;
        logic [7:0]  held_command;
        logic [7:0]  held_feedback;
        logic [15:0] held_parameter;
        logic [7:0]  held_check_high;
    } frame_state_t;

    typedef struct packed {
        logic        valid;
        status_t     status;
        logic [7:0]  reply_command;
        logic [7:0]  reply_feedback;
        logic [15:0] reply_parameter;
    } result_t;

endpackage

// ----- hw/rtl/srfr_step.sv -----
`timescale 1ns / 1ps

module srfr_step (
    input  srfr_pkg::frame_state_t st,
    input  srfr_pkg::cfg_t         cfg,
    input  logic [1:0]             cmd,
    input  logic [7:0]             rx_byte,
    output srfr_pkg::frame_state_t st_next,
    output srfr_pkg::result_t      res
);

    logic        is_byte;
    logic        is_tick;
    logic        is_arm;
    logic [15:0] elapsed_inc;
    logic        timed_out;
    logic [10:0] sum;
    logic [15:0] calc;
    logic [15:0] got;
    logic        fail;
    logic        done;
    srfr_pkg::status_t fail_status;

    assign is_byte = (cmd == srfr_pkg::CMD_BYTE) && st.armed;
    assign is_tick = (cmd == srfr_pkg::CMD_TICK) && st.armed;
    assign is_arm  = (cmd == srfr_pkg::CMD_ARM);

    // saturating tick count
    assign elapsed_inc = (st.elapsed != srfr_pkg::ELAPSED_MAX) ? st.elapsed + 16'd1
                                                               : st.elapsed;
    assign timed_out   = elapsed_inc >= cfg.timeout_ticks;

    assign sum  = {3'b000, cfg.version_code} + {3'b000, cfg.length_code}
                + {3'b000, st.held_command} + {3'b000, st.held_feedback}
                + {3'b000, st.held_parameter[15:8]} + {3'b000, st.held_parameter[7:0]};
    assign calc = 16'd0 - {5'b00000, sum};
    assign got  = {st.held_check_high, rx_byte};

    // frame checks per phase
    always_comb begin
        fail        = 1'b0;
        done        = 1'b0;
        fail_status = srfr_pkg::ST_OK;
        if (is_byte) begin
            case (st.phase)
                srfr_pkg::PH_VERSION: begin
                    fail        = rx_byte != cfg.version_code;
                    fail_status = srfr_pkg::ST_VERSION;
                end
                srfr_pkg::PH_LENGTH: begin
                    fail        = rx_byte != cfg.length_code;
                    fail_status = srfr_pkg::ST_LENGTH;
                end
                srfr_pkg::PH_CHECK_LO: begin
                    fail        = got != calc;
                    fail_status = srfr_pkg::ST_CHECKSUM;
                end
                srfr_pkg::PH_END: begin
                    done        = 1'b1;
                    fail        = rx_byte != cfg.end_code;
                    fail_status = srfr_pkg::ST_END;
                end
                default: begin
                    fail = 1'b0;
                end
            endcase
        end else if (is_tick && timed_out) begin
            fail        = 1'b1;
            fail_status = srfr_pkg::ST_TIMEOUT;
        end
    end

    // next state
    always_comb begin
        st_next = st;
        if (is_arm) begin
            st_next.armed   = 1'b1;
            st_next.elapsed = 16'd0;
            st_next.phase   = srfr_pkg::PH_START;
        end else if (is_tick) begin
            st_next.elapsed = elapsed_inc;
        end else if (is_byte) begin
            case (st.phase)
                srfr_pkg::PH_START: begin
                    if (rx_byte == cfg.start_code) begin
                        st_next.phase = srfr_pkg::PH_VERSION;
                    end
                end
                srfr_pkg::PH_VERSION:  st_next.phase = srfr_pkg::PH_LENGTH;
                srfr_pkg::PH_LENGTH:   st_next.phase = srfr_pkg::PH_COMMAND;
                srfr_pkg::PH_COMMAND: begin
                    st_next.held_command = rx_byte;
                    st_next.phase        = srfr_pkg::PH_FEEDBACK;
                end
                srfr_pkg::PH_FEEDBACK: begin
                    st_next.held_feedback = rx_byte;
                    st_next.phase         = srfr_pkg::PH_PARAM_HI;
                end
                srfr_pkg::PH_PARAM_HI: begin
                    st_next.held_parameter = {rx_byte, 8'h00};
                    st_next.phase          = srfr_pkg::PH_PARAM_LO;
                end
                srfr_pkg::PH_PARAM_LO: begin
                    st_next.held_parameter = {st.held_parameter[15:8], rx_byte};
                    st_next.phase          = srfr_pkg::PH_CHECK_HI;
                end
                srfr_pkg::PH_CHECK_HI: begin
                    st_next.held_check_high = rx_byte;
                    st_next.phase           = srfr_pkg::PH_CHECK_LO;
                end
                srfr_pkg::PH_CHECK_LO: st_next.phase = srfr_pkg::PH_END;
                default:               st_next.phase = srfr_pkg::PH_START;
            endcase
        end
        if (fail || done) begin
            st_next.phase = srfr_pkg::PH_START;
            st_next.armed = 1'b0;
        end
    end

    // result
    always_comb begin
        res.valid           = fail || done;
        res.status          = fail ? fail_status : srfr_pkg::ST_OK;
        res.reply_command   = 8'd0;
        res.reply_feedback  = 8'd0;
        res.reply_parameter = 16'd0;
        if (done && !fail) begin
            res.reply_command   = st.held_command;
            res.reply_feedback  = st.held_feedback;
            res.reply_parameter = st.held_parameter;
        end
    end

endmodule

// ----- hw/rtl/serial_reply_frame_receiver.sv -----
`timescale 1ns / 1ps

// channel  direction  handshake          payload
// s_       in         s_valid / s_ready  s_cmd, s_rx_byte
// m_       out        m_valid / m_ready  m_status, m_reply_command, m_reply_feedback,
//                                        m_reply_parameter
// cfg_     in         cfg_wr_en          cfg_index, cfg_wr_data
//
// one transfer per cycle while s_ready is high: each item is decoded against the frame state
// combinationally and any result lands in the output register on the same edge
// s_ready is high whenever the output register is empty or being drained
// a result waiting on m_ready holds off new items, nothing else stalls
// synchronous active-low reset: disarmed, hunting for start, registers at defaults

module serial_reply_frame_receiver (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [7:0]  s_rx_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [7:0]  m_reply_command,
    output logic [7:0]  m_reply_feedback,
    output logic [15:0] m_reply_parameter,

    input  logic                          cfg_wr_en,
    input  logic [srfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srfr_pkg::CFG_DATA_W-1:0] cfg_wr_data
);

    srfr_pkg::cfg_t         cfg_reg;
    srfr_pkg::frame_state_t st_reg;
    srfr_pkg::frame_state_t st_next;
    srfr_pkg::result_t      res;
    srfr_pkg::result_t      out_reg;
    logic                   accept;

    assign s_ready = !out_reg.valid || m_ready;
    assign accept  = s_valid && s_ready;

    srfr_step u_step (
        .st      (st_reg),
        .cfg     (cfg_reg),
        .cmd     (s_cmd),
        .rx_byte (s_rx_byte),
        .st_next (st_next),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_code    <= srfr_pkg::START_RESET;
            cfg_reg.version_code  <= srfr_pkg::VERSION_RESET;
            cfg_reg.length_code   <= srfr_pkg::LENGTH_RESET;
            cfg_reg.end_code      <= srfr_pkg::END_RESET;
            cfg_reg.timeout_ticks <= srfr_pkg::TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                srfr_pkg::CFG_START:   cfg_reg.start_code    <= cfg_wr_data[7:0];
                srfr_pkg::CFG_VERSION: cfg_reg.version_code  <= cfg_wr_data[7:0];
                srfr_pkg::CFG_LENGTH:  cfg_reg.length_code   <= cfg_wr_data[7:0];
                srfr_pkg::CFG_END:     cfg_reg.end_code      <= cfg_wr_data[7:0];
                srfr_pkg::CFG_TIMEOUT: cfg_reg.timeout_ticks <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.phase           <= srfr_pkg::PH_START;
            st_reg.armed           <= 1'b0;
            st_reg.elapsed         <= 16'd0;
            st_reg.held_command    <= 8'd0;
            st_reg.held_feedback   <= 8'd0;
            st_reg.held_parameter  <= 16'd0;
            st_reg.held_check_high <= 8'd0;
        end else if (accept) begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.valid <= 1'b0;
        end else if (accept) begin
            out_reg.valid <= res.valid;
        end else if (m_ready) begin
            out_reg.valid <= 1'b0;
        end
        if (accept && res.valid) begin
            out_reg.status          <= res.status;
            out_reg.reply_command   <= res.reply_command;
            out_reg.reply_feedback  <= res.reply_feedback;
            out_reg.reply_parameter <= res.reply_parameter;
        end
    end

    assign m_valid           = out_reg.valid;
    assign m_status          = out_reg.status;
    assign m_reply_command   = out_reg.reply_command;
    assign m_reply_feedback  = out_reg.reply_feedback;
    assign m_reply_parameter = out_reg.reply_parameter;

    a_result_disarms : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !st_reg.armed)
        else $error("result pending while still armed");

    a_disarmed_hunts : assert property (@(posedge aclk) disable iff (!aresetn)
        !st_reg.armed |-> (st_reg.phase == srfr_pkg::PH_START))
        else $error("disarmed outside hunting phase");

    a_error_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != srfr_pkg::ST_OK)) |->
            ((m_reply_command == 8'd0) && (m_reply_feedback == 8'd0)
             && (m_reply_parameter == 16'd0)))
        else $error("error result carries frame data");

    a_result_from_item : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready))
        else $error("result without an accepted item");

endmodule
